// ----- src/ppm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

    // Palette geometry.
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // Field widths.
    localparam int IDX_W      = 8;
    localparam int COLOR_W    = 24;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    // Luma weights and the widths of their products with an 8-bit channel.
    localparam logic [7:0] LUMA_R_COEF = 8'd77;
    localparam logic [7:0] LUMA_G_COEF = 8'd150;
    localparam logic [7:0] LUMA_B_COEF = 8'd29;
    localparam int PR_W  = 15;
    localparam int PG_W  = 16;
    localparam int PB_W  = 13;
    localparam int SUM_W = 16;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_PIXEL = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREYSCALE = 2'd0,
        CFG_SCANLINE  = 2'd1
    } cfg_sel_t;

    // Side information that travels with a colour down the pipeline.
    typedef struct packed {
        logic is_pixel;
        logic row_odd;
    } ppm_tag_t;

endpackage

`default_nettype wire

// ----- src/ppm_palette.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppm_palette
    import ppm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [IDX_W-1:0]    index,
    input  logic [COLOR_W-1:0]  color,
    input  logic                row_odd,
    output logic                s1_valid,
    input  logic                s1_ready,
    output ppm_tag_t            s1_tag,
    output logic [COLOR_W-1:0]  s1_color
);

    localparam logic [IDX_W:0] ENTRIES_LIM = (IDX_W + 1)'(PALETTE_ENTRIES);

    logic [COLOR_W-1:0]         palette_reg [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] entry_valid_reg;
    logic [PALETTE_ENTRIES-1:0] entry_valid_next;
    logic [COLOR_W-1:0]         rd_data_reg;
    logic                       hit_reg;
    logic                       hit_next;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    ppm_tag_t                   tag_reg;
    ppm_tag_t                   tag_next;

    logic              accept;
    logic              in_range;
    logic              produces;
    logic              wr_en;
    logic [PAL_AW-1:0] addr;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;
    assign in_range = {1'b0, index} < ENTRIES_LIM;
    assign addr     = index[PAL_AW-1:0];
    assign produces = (action == ACT_READ) || (action == ACT_PIXEL);
    assign wr_en    = accept && (action == ACT_WRITE) && in_range;

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        if (wr_en)
        begin
            entry_valid_next[addr] = 1'b1;
        end
        s1_valid_next     = in_ready ? (in_valid && produces) : s1_valid_reg;
        hit_next          = in_range && entry_valid_reg[addr];
        tag_next.is_pixel = (action == ACT_PIXEL);
        tag_next.row_odd  = row_odd;
    end

    // Palette memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_reg[addr] <= color;
        end
        if (accept)
        begin
            rd_data_reg <= palette_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            s1_valid_reg    <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg <= hit_next;
            tag_reg <= tag_next;
        end
    end

    // An entry never written since reset reads as black.
    assign s1_valid = s1_valid_reg;
    assign s1_tag   = tag_reg;
    assign s1_color = hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ----- src/ppm_colour_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppm_colour_pipe
    import ppm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    output logic                s1_ready,
    input  ppm_tag_t            s1_tag,
    input  logic [COLOR_W-1:0]  s1_color,
    input  logic                greyscale_enable,
    input  logic                scanline_enable,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PIX_W-1:0]    pixel_out,
    output logic [COLOR_W-1:0]  read_color
);

    // Stage two: luma products.
    logic               s2_valid_reg;
    logic               s2_valid_next;
    ppm_tag_t           s2_tag_reg;
    logic [COLOR_W-1:0] s2_raw_reg;
    logic [PR_W-1:0]    pr_reg;
    logic [PG_W-1:0]    pg_reg;
    logic [PB_W-1:0]    pb_reg;
    logic [PR_W-1:0]    pr_next;
    logic [PG_W-1:0]    pg_next;
    logic [PB_W-1:0]    pb_next;

    // Stage three: output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIX_W-1:0]   pixel_reg;
    logic [PIX_W-1:0]   pixel_next;
    logic [COLOR_W-1:0] read_reg;
    logic [COLOR_W-1:0] read_next;

    logic               out_free;
    logic               s2_load;
    logic [SUM_W-1:0]   luma_sum;
    logic [7:0]         luma;
    logic [PIX_W-1:0]   packed_raw;
    logic [PIX_W-1:0]   packed_grey;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_ready = !s2_valid_reg || out_free;
    assign s2_load  = s1_valid && s1_ready;

    assign pr_next = PR_W'(s1_color[23:16]) * PR_W'(LUMA_R_COEF);
    assign pg_next = PG_W'(s1_color[15:8])  * PG_W'(LUMA_G_COEF);
    assign pb_next = PB_W'(s1_color[7:0])   * PB_W'(LUMA_B_COEF);

    assign s2_valid_next  = s1_ready ? s1_valid : s2_valid_reg;
    assign out_valid_next = out_free ? s2_valid_reg : out_valid_reg;

    // The weights add up to 256, so the sum never exceeds sixteen bits.
    assign luma_sum    = SUM_W'(pr_reg) + SUM_W'(pg_reg) + SUM_W'(pb_reg);
    assign luma        = luma_sum[15:8];
    assign packed_raw  = {s2_raw_reg[23:21], s2_raw_reg[15:13], s2_raw_reg[7:6]};
    assign packed_grey = {luma[7:5], luma[7:5], luma[7:6]};

    always_comb
    begin
        pixel_next = '0;
        read_next  = '0;
        if (s2_tag_reg.is_pixel)
        begin
            if (!(scanline_enable && s2_tag_reg.row_odd))
            begin
                pixel_next = greyscale_enable ? packed_grey : packed_raw;
            end
        end
        else
        begin
            read_next = s2_raw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_tag_reg <= s1_tag;
            s2_raw_reg <= s1_color;
            pr_reg     <= pr_next;
            pg_reg     <= pg_next;
            pb_reg     <= pb_next;
        end
        if (out_free && s2_valid_reg)
        begin
            pixel_reg <= pixel_next;
            read_reg  <= read_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_reg;
    assign read_color = read_reg;

endmodule

`default_nettype wire

// ----- src/palette_pixel_mapper_rgb332_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   ------------------------------------------
// in        in_valid/in_ready    action, index, color, row_odd
// out       out_valid/out_ready  pixel_out, read_color
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word is taken on the input in every cycle while the input is not stalled.
// A read or pixel word is offered once it has passed the palette read, the luma
// products and the output register; writes and unused action codes give none.
// Reset clears the palette at once through one valid flag per entry, so words are
// taken from the first cycle after reset. An output stall fills the stages behind
// it and the input only stalls once all three are full; nothing is lost.

module palette_pixel_mapper_rgb332_top
    import ppm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [IDX_W-1:0]      index,
    input  logic [COLOR_W-1:0]    color,
    input  logic                  row_odd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      pixel_out,
    output logic [COLOR_W-1:0]    read_color,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic               grey_reg;
    logic               grey_next;
    logic               scan_reg;
    logic               scan_next;
    logic               s1_valid;
    logic               s1_ready;
    ppm_tag_t           s1_tag;
    logic [COLOR_W-1:0] s1_color;

    // Config registers are always ready. The user must change them only while the
    // pipeline is empty (not checked); the final stage samples them directly.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        grey_next = grey_reg;
        scan_next = scan_reg;
        if (cfg_valid)
        begin
            case (cfg_sel_t'(cfg_index))
                CFG_GREYSCALE: grey_next = cfg_data[0];
                CFG_SCANLINE:  scan_next = cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grey_reg <= 1'b0;
            scan_reg <= 1'b0;
        end
        else
        begin
            grey_reg <= grey_next;
            scan_reg <= scan_next;
        end
    end

    // Stage one: palette store with its registered read.
    ppm_palette u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .index    (index),
        .color    (color),
        .row_odd  (row_odd),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_tag   (s1_tag),
        .s1_color (s1_color)
    );

    // Stages two and three: luma products, then grey select, packing,
    // scanline blanking and the output register.
    ppm_colour_pipe u_colour_pipe (
        .clk              (clk),
        .rst_n            (rst_n),
        .s1_valid         (s1_valid),
        .s1_ready         (s1_ready),
        .s1_tag           (s1_tag),
        .s1_color         (s1_color),
        .greyscale_enable (grey_reg),
        .scanline_enable  (scan_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pixel_out        (pixel_out),
        .read_color       (read_color)
    );

endmodule

`default_nettype wire

// ----- src/ppm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppm_checker
    import ppm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            action,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [PIX_W-1:0]      pixel_out,
    input  logic [COLOR_W-1:0]    read_color
);

    // A result word held under back-pressure keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(read_color))
    else $error("result word changed while stalled");

    // A read result carries no pixel, a pixel result no raw colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_color != '0) |-> (pixel_out == '0))
    else $error("result word has both fields set");

    // Reset empties the pipeline.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("result offered during reset");

    // With the output always ready, a read or pixel word appears after the
    // palette read, the luma products and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready &&
         (action == ACT_READ || action == ACT_PIXEL))
        ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind palette_pixel_mapper_rgb332_top ppm_checker u_ppm_checker (.*);

`default_nettype wire

// ----- tb/sv/palette_pixel_mapper_rgb332_checker.sv -----
`timescale 1ns / 1ps

module palette_pixel_mapper_rgb332_checker
    import ppm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [IDX_W-1:0]      index,
    input  logic [COLOR_W-1:0]    color,
    input  logic                  row_odd,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [PIX_W-1:0]      pixel_out,
    input  logic [COLOR_W-1:0]    read_color,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_checked
);

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COLOR_W-1:0] raw;
    } lookup_result_t;

    logic [COLOR_W-1:0] shadow_palette [PALETTE_ENTRIES];
    logic               grey_on;
    logic               scan_on;
    lookup_result_t     awaited_q [$];
    lookup_result_t     due;
    lookup_result_t     seen;
    int                 errors;
    int                 checked;

    function automatic logic [COLOR_W-1:0] palette_colour(input logic [IDX_W-1:0] idx);
        if (int'(idx) >= PALETTE_ENTRIES)
            return '0;
        return shadow_palette[idx];
    endfunction

    // Optional luma reduction, then keep the top 3/3/2 bits of red/green/blue.
    function automatic logic [PIX_W-1:0] rgb332_pixel(input logic [COLOR_W-1:0] c,
                                                      input logic grey);
        int unsigned luma;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        red   = c[23:16];
        green = c[15:8];
        blue  = c[7:0];
        if (grey)
        begin
            luma  = (77 * red + 150 * green + 29 * blue) >> 8;
            red   = luma[7:0];
            green = luma[7:0];
            blue  = luma[7:0];
        end
        return {red[7:5], green[7:5], blue[7:6]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (shadow_palette[i])
                shadow_palette[i] = '0;
            grey_on = 1'b0;
            scan_on = 1'b0;
            awaited_q.delete();
            errors  = 0;
            checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = '{pixel: pixel_out, raw: read_color};
                if (awaited_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("Unexpected result word: pixel_out %02h read_color %06h",
                                 seen.pixel, seen.raw);
                    errors++;
                end
                else
                begin
                    due = awaited_q.pop_front();
                    checked++;
                    if (seen.pixel !== due.pixel || seen.raw !== due.raw)
                    begin
                        if (errors < 10)
                            $display("Mismatch on result %0d: expected pixel_out %02h %s read_color %06h %s, got %02h / %06h",
                                     checked, due.pixel,
                                     (seen.pixel !== due.pixel) ? "(wrong)" : "(ok)",
                                     due.raw,
                                     (seen.raw !== due.raw) ? "(wrong)" : "(ok)",
                                     seen.pixel, seen.raw);
                        errors++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_sel_t'(cfg_index))
                    CFG_GREYSCALE: grey_on = cfg_data[0];
                    CFG_SCANLINE:  scan_on = cfg_data[0];
                    default:       ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                case (action_t'(action))
                    ACT_WRITE:
                    begin
                        if (int'(index) < PALETTE_ENTRIES)
                            shadow_palette[index] = color;
                    end
                    ACT_READ:
                    begin
                        due.pixel = '0;
                        due.raw   = palette_colour(index);
                        awaited_q.push_back(due);
                    end
                    ACT_PIXEL:
                    begin
                        if (scan_on && row_odd)
                            due.pixel = '0;
                        else
                            due.pixel = rgb332_pixel(palette_colour(index), grey_on);
                        due.raw = '0;
                        awaited_q.push_back(due);
                    end
                    default: ;
                endcase
            end
        end
        mismatches      <= errors;
        outstanding     <= awaited_q.size();
        results_checked <= checked;
    end

endmodule

// ----- tb/sv/palette_pixel_mapper_rgb332_top_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the palette mapper. The checker beside the block
// keeps its own palette and register copies, predicts every result word and
// compares; this module only produces words, idles both sides and decides.
module palette_pixel_mapper_rgb332_top_tb;
    import ppm_pkg::*;

    // The unused action code and a register index beyond the list; both must
    // be ignored by the block.
    localparam logic [1:0]           ACT_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    // Counted words (writes, reads and pixels) for the whole run.
    localparam int TARGET_WORDS  = 1950;
    localparam int PHASE_WORDS   = 325;
    // A write leaves no result, so after the last result the block may still
    // be storing one; three pipeline stages, with margin.
    localparam int SETTLE_CYCLES = 6;
    // Cycles without any accepted word on any channel before giving up.
    localparam int STALL_LIMIT   = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            action;
    logic [IDX_W-1:0]      index;
    logic [COLOR_W-1:0]    color;
    logic                  row_odd;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      pixel_out;
    logic [COLOR_W-1:0]    read_color;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int results_checked;

    int idle_cycles = 0;
    int n_writes    = 0;
    int n_reads     = 0;
    int n_pixels    = 0;
    int n_unused    = 0;
    int n_settings  = 0;
    bit steady_sender = 1'b0;

    palette_pixel_mapper_rgb332_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .index      (index),
        .color      (color),
        .row_odd    (row_odd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .read_color (read_color),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    palette_pixel_mapper_rgb332_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .index           (index),
        .color           (color),
        .row_odd         (row_odd),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_out       (pixel_out),
        .read_color      (read_color),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: any accepted word on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("No progress for %0d cycles with %0d results still due.",
                         STALL_LIMIT, outstanding);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Mostly no pause, now and then a few cycles, rarely a long one.
    function automatic int pause_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // The result side: runs of ready broken by stalls, and sometimes a long
    // run with no stall at all so the pipeline streams at full rate.
    initial
    begin : sink_driver
        int run;
        int hold;
        out_ready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                run = $urandom_range(100, 300);
            else
                run = $urandom_range(1, 12);
            hold = pause_length();
            @(posedge clk);
            out_ready <= 1'b1;
            repeat (run - 1) @(posedge clk);
            if (hold > 0)
            begin
                @(posedge clk);
                out_ready <= 1'b0;
                repeat (hold - 1) @(posedge clk);
            end
        end
    end

    // Presents one word and returns in the time step of its acceptance. Valid
    // is only dropped when a pause precedes the word, so back-to-back words
    // keep it high throughout.
    task automatic send_word(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                             input logic [COLOR_W-1:0] col, input logic odd);
        int gap;
        gap = steady_sender ? 0 : pause_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        index    <= idx;
        color    <= col;
        row_odd  <= odd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (act)
            ACT_WRITE: n_writes++;
            ACT_READ:  n_reads++;
            ACT_PIXEL: n_pixels++;
            default:   n_unused++;
        endcase
    endtask

    // Stops the sender and waits until every predicted result has been taken,
    // then lets any trailing palette write settle. The checker's count is
    // registered, so the first edge is always waited out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high on return; the caller lowers it after its last
    // write so that consecutive writes never drop and raise it in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic grey, input logic scan);
        drain();
        write_reg(CFG_GREYSCALE, grey);
        write_reg(CFG_SCANLINE, scan);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Half the indices come from a small window so that lookups mostly hit
    // entries written shortly before; the rest spread over the whole palette.
    function automatic logic [IDX_W-1:0] pick_index(input int base);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return IDX_W'(base + $urandom_range(0, 7));
        if (roll < 9)
            return IDX_W'($urandom_range(0, 255));
        return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    endfunction

    // Colours sitting on the packing thresholds are worth more than their
    // share of random draws.
    function automatic logic [COLOR_W-1:0] pick_colour();
        if ($urandom_range(0, 9) < 8)
            return COLOR_W'($urandom);
        case ($urandom_range(0, 4))
            0:       return 24'h000000;
            1:       return 24'hffffff;
            2:       return 24'he0e0c0;
            3:       return 24'h1f1f3f;
            default: return 24'h808080;
        endcase
    endfunction

    initial
    begin : stimulus
        int base;
        int phase_end;
        int reps;
        logic [IDX_W-1:0] slot;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        action    <= ACT_WRITE;
        index     <= '0;
        color     <= '0;
        row_odd   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_GREYSCALE;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset values are written explicitly first; then the
        // palette must read back as all zero before anything is stored.
        set_mode(1'b0, 1'b0);
        send_word(ACT_READ,  8'h00, 24'h000000, 1'b0);
        send_word(ACT_READ,  8'hff, 24'hffffff, 1'b1);
        send_word(ACT_PIXEL, 8'h80, 24'h000000, 1'b0);

        // Extremes of index and colour, plus colours just on and just under
        // the bits that survive packing.
        send_word(ACT_WRITE, 8'h00, 24'hffffff, 1'b0);
        send_word(ACT_WRITE, 8'hff, 24'hffffff, 1'b1);
        send_word(ACT_WRITE, 8'h01, 24'he0e0c0, 1'b0);
        send_word(ACT_WRITE, 8'h02, 24'h1f1f3f, 1'b0);
        send_word(ACT_WRITE, 8'h80, 24'h123456, 1'b0);
        send_word(ACT_WRITE, 8'h7f, 24'hedcba9, 1'b1);
        send_word(ACT_READ,  8'h00, 24'h000000, 1'b0);
        send_word(ACT_READ,  8'hff, 24'h000000, 1'b0);
        send_word(ACT_READ,  8'h01, 24'h000000, 1'b1);
        send_word(ACT_PIXEL, 8'h00, 24'h000000, 1'b0);
        send_word(ACT_PIXEL, 8'h01, 24'hffffff, 1'b1);
        send_word(ACT_PIXEL, 8'h02, 24'h000000, 1'b0);
        send_word(ACT_PIXEL, 8'hff, 24'h000000, 1'b1);

        // The unused action code carries a colour that would overwrite entry
        // zero if it were mistaken for a write.
        send_word(ACT_UNUSED, 8'h00, 24'h000000, 1'b1);
        send_word(ACT_READ,   8'h00, 24'h000000, 1'b0);

        // A register index beyond the list must change neither mode.
        drain();
        write_reg(CFG_UNUSED, 1'b1);
        cfg_valid <= 1'b0;
        send_word(ACT_PIXEL, 8'h80, 24'h000000, 1'b1);
        send_word(ACT_PIXEL, 8'h7f, 24'h000000, 1'b1);

        // Each mode against entries written under the plain mode.
        set_mode(1'b1, 1'b0);
        send_word(ACT_PIXEL, 8'h00, 24'h000000, 1'b0);
        send_word(ACT_PIXEL, 8'h80, 24'h000000, 1'b1);
        set_mode(1'b0, 1'b1);
        send_word(ACT_PIXEL, 8'h00, 24'h000000, 1'b1);
        send_word(ACT_PIXEL, 8'h00, 24'h000000, 1'b0);
        set_mode(1'b1, 1'b1);
        send_word(ACT_PIXEL, 8'hff, 24'h000000, 1'b1);
        send_word(ACT_PIXEL, 8'h7f, 24'h000000, 1'b0);

        // Random part in phases, one register setting per phase: the four
        // combinations in turn, then random ones. Each phase change drains
        // the pipeline first. Most traffic stores a colour and then looks it
        // up; the remainder is loose words including the unused code.
        while (n_writes + n_reads + n_pixels < TARGET_WORDS)
        begin
            case (n_settings)
                4:       set_mode(1'b0, 1'b0);
                5:       set_mode(1'b1, 1'b1);
                6:       set_mode(1'b1, 1'b0);
                7:       set_mode(1'b0, 1'b1);
                default: set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            base          = $urandom_range(0, 248);
            steady_sender = ($urandom_range(0, 3) == 0);
            phase_end     = n_writes + n_reads + n_pixels + PHASE_WORDS;
            while (n_writes + n_reads + n_pixels < phase_end)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    slot = pick_index(base);
                    send_word(ACT_WRITE, slot, pick_colour(), 1'($urandom_range(0, 1)));
                    reps = $urandom_range(1, 4);
                    repeat (reps)
                        send_word(($urandom_range(0, 3) == 0) ? ACT_READ : ACT_PIXEL,
                                  slot, COLOR_W'($urandom), 1'($urandom_range(0, 1)));
                end
                else
                    send_word(2'($urandom_range(0, 3)), pick_index(base), pick_colour(),
                              1'($urandom_range(0, 1)));
            end
        end
        steady_sender = 1'b0;

        // Let everything predicted arrive, then watch a few more cycles for
        // stray result words.
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d palette writes, %0d reads, %0d pixels and %0d unused-code words",
                 n_writes, n_reads, n_pixels, n_unused);
        $display("under %0d register settings; %0d result words compared.",
                 n_settings, results_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/ppm_pkg.sv
src/ppm_palette.sv
src/ppm_colour_pipe.sv
src/palette_pixel_mapper_rgb332_top.sv
src/ppm_checker.sv
tb/sv/palette_pixel_mapper_rgb332_checker.sv
tb/sv/palette_pixel_mapper_rgb332_top_tb.sv
